@@ src/ftc_pkg.sv @@
package ftc_pkg;

    // Channel set and sample format
    localparam int NUM_CHANNELS = 3;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_W         = 2;
    localparam int MASK_W       = 3;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'h7;

    // Reference table and arithmetic widths
    localparam int TABLE_LEN   = 40;
    localparam int PHASE_W     = 6;
    localparam int MARK_STEP   = 6;
    localparam int SPACE_STEP  = 11;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_BITS + COEF_W;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 32;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Output bus layout
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        TONE_NONE  = 2'd0,
        TONE_MARK  = 2'd1,
        TONE_SPACE = 2'd2
    } tone_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [COEF_W-1:0]      mark_coef;
        logic signed [COEF_W-1:0]      space_coef;
        logic [CH_W-1:0]               channel;
        logic                          last;
        logic                          valid;
        logic                          active;
    } ftc_item_t;

    // Q1.15 sine, one full period over the table
    function automatic logic signed [COEF_W-1:0] sine_q15(input logic [PHASE_W-1:0] idx);
        logic signed [COEF_W-1:0] v;
        case (idx)
            6'd0:  v = 16'sd0;
            6'd1:  v = 16'sd5126;
            6'd2:  v = 16'sd10126;
            6'd3:  v = 16'sd14876;
            6'd4:  v = 16'sd19260;
            6'd5:  v = 16'sd23170;
            6'd6:  v = 16'sd26509;
            6'd7:  v = 16'sd29196;
            6'd8:  v = 16'sd31163;
            6'd9:  v = 16'sd32364;
            6'd10: v = 16'sd32767;
            6'd11: v = 16'sd32364;
            6'd12: v = 16'sd31163;
            6'd13: v = 16'sd29196;
            6'd14: v = 16'sd26509;
            6'd15: v = 16'sd23170;
            6'd16: v = 16'sd19260;
            6'd17: v = 16'sd14876;
            6'd18: v = 16'sd10126;
            6'd19: v = 16'sd5126;
            6'd20: v = 16'sd0;
            6'd21: v = -16'sd5126;
            6'd22: v = -16'sd10126;
            6'd23: v = -16'sd14876;
            6'd24: v = -16'sd19260;
            6'd25: v = -16'sd23170;
            6'd26: v = -16'sd26509;
            6'd27: v = -16'sd29196;
            6'd28: v = -16'sd31163;
            6'd29: v = -16'sd32364;
            6'd30: v = -16'sd32767;
            6'd31: v = -16'sd32364;
            6'd32: v = -16'sd31163;
            6'd33: v = -16'sd29196;
            6'd34: v = -16'sd26509;
            6'd35: v = -16'sd23170;
            6'd36: v = -16'sd19260;
            6'd37: v = -16'sd14876;
            6'd38: v = -16'sd10126;
            6'd39: v = -16'sd5126;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Advance a table index by a fixed step, wrapping at the table length
    function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] ph,
                                                      input logic [PHASE_W-1:0] step);
        logic [PHASE_W:0] s;
        s = {1'b0, ph} + {1'b0, step};
        if (s >= (PHASE_W+1)'(TABLE_LEN)) begin
            s = s - (PHASE_W+1)'(TABLE_LEN);
        end
        return s[PHASE_W-1:0];
    endfunction

    // Signed add that clamps to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [PROD_W-1:0] prod);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(prod);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    // Magnitude of an accumulator value; the most negative value fits unsigned
    function automatic logic [ACC_W-1:0] acc_abs(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] u;
        u = v;
        return v[ACC_W-1] ? (~u + ACC_W'(1)) : u;
    endfunction

endpackage

@@ src/fsk_tone_correlator_core.sv @@
// FSK tone correlator (Bell 202 style, mark 1200 Hz, space 2200 Hz at 8 kHz).
// Takes one signed Q1.15 sample per cycle while the queue has room on the s_axis
// side, with its channel in tuser and the end of a buffer in tlast. Each sample of
// an enabled channel is multiplied by two sine references and summed in saturating
// 48-bit accumulators; the last sample of a buffer decides that channel's tone and
// carrier and sends one status item on m_axis; channels past the third give none.
// Throughput is one item per cycle unless the output is held, set by the single
// multiply-accumulate pair of the back end. A decision goes from the four-entry
// input queue through the product, accumulation and magnitude registers to the
// output register; while a result waits there, the queue fills with new items.
// Write active_mask via cfg_wr_en / cfg_wr_data only while idle; not enforced.
module fsk_tone_correlator_core
    import ftc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [MASK_W-1:0]      cfg_wr_data,      // active_mask
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,     // [15:0] sample
    input  logic [CH_W-1:0]        s_axis_tuser,     // [1:0] channel
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] tone, [2] carrier_on, [34:3] packet_count, [66:35] error_count
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    output logic [CH_W-1:0]        m_axis_tuser      // [1:0] out_channel
);

    logic      push_valid;
    logic      push_ready;
    ftc_item_t push_item;
    logic      q_valid;
    logic      q_ready;
    ftc_item_t q_item;

    ftc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    ftc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ftc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ src/ftc_front.sv @@
module ftc_front
    import ftc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [MASK_W-1:0]      cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,
    input  logic [CH_W-1:0]        s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   push_valid,
    input  logic                   push_ready,
    output ftc_item_t              push_item
);

    logic [MASK_W-1:0]  mask_reg;
    logic [PHASE_W-1:0] mark_ph_reg;
    logic [PHASE_W-1:0] mark_ph_next;
    logic [PHASE_W-1:0] space_ph_reg;
    logic [PHASE_W-1:0] space_ph_next;
    logic               accept;
    logic               ch_valid;
    logic               ch_active;

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;
    assign accept        = s_axis_tvalid && push_ready;

    // Classify the channel against the enable mask
    assign ch_valid  = (32'(s_axis_tuser) < NUM_CHANNELS);
    assign ch_active = ch_valid && mask_reg[s_axis_tuser];

    // Build the item: inactive items carry zero references
    always_comb begin
        push_item.sample     = $signed(s_axis_tdata);
        push_item.mark_coef  = ch_active ? sine_q15(mark_ph_reg) : '0;
        push_item.space_coef = ch_active ? sine_q15(space_ph_reg) : '0;
        push_item.channel    = s_axis_tuser;
        push_item.last       = s_axis_tlast;
        push_item.valid      = ch_valid;
        push_item.active     = ch_active;
    end

    // Advance phase on active items, restart at end of buffer
    always_comb begin
        mark_ph_next  = mark_ph_reg;
        space_ph_next = space_ph_reg;
        if (accept) begin
            if (s_axis_tlast) begin
                mark_ph_next  = '0;
                space_ph_next = '0;
            end else if (ch_active) begin
                mark_ph_next  = phase_step(mark_ph_reg, PHASE_W'(MARK_STEP));
                space_ph_next = phase_step(space_ph_reg, PHASE_W'(SPACE_STEP));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= MASK_RESET;
            mark_ph_reg  <= '0;
            space_ph_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                mask_reg <= cfg_wr_data;
            end
            mark_ph_reg  <= mark_ph_next;
            space_ph_reg <= space_ph_next;
        end
    end

endmodule

@@ src/ftc_queue.sv @@
module ftc_queue
    import ftc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ftc_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output ftc_item_t out_item
);

    ftc_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Move pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ src/ftc_back.sv @@
module ftc_back
    import ftc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ftc_item_t            q_item,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [CH_W-1:0]      m_axis_tuser
);

    logic adv;

    // Stage 1: products
    logic                     v1_reg;
    logic                     last1_reg;
    logic                     valid1_reg;
    logic                     active1_reg;
    logic [CH_W-1:0]          ch1_reg;
    logic signed [PROD_W-1:0] mprod1_reg;
    logic signed [PROD_W-1:0] sprod1_reg;

    // Stage 2: accumulation
    logic signed [ACC_W-1:0] mark_acc_reg;
    logic signed [ACC_W-1:0] space_acc_reg;
    logic signed [ACC_W-1:0] mark_acc_upd;
    logic signed [ACC_W-1:0] space_acc_upd;
    logic signed [ACC_W-1:0] mark_fin_reg;
    logic signed [ACC_W-1:0] space_fin_reg;
    logic                    v2_reg;
    logic                    active2_reg;
    logic [CH_W-1:0]         ch2_reg;

    // Stage 3: magnitudes
    logic [ACC_W-1:0] mark_abs_reg;
    logic [ACC_W-1:0] space_abs_reg;
    logic             v3_reg;
    logic             active3_reg;
    logic [CH_W-1:0]  ch3_reg;

    // Per-channel status
    logic       carrier_reg [NUM_CHANNELS];
    tone_t      tone_reg    [NUM_CHANNELS];
    logic [CNT_W-1:0] pkt_cnt_reg [NUM_CHANNELS];
    logic [CNT_W-1:0] err_cnt_reg [NUM_CHANNELS];

    logic             carrier_next;
    tone_t            tone_next;
    logic [CNT_W-1:0] pkt_next;
    logic [CNT_W-1:0] err_next;
    logic             mark_wins;
    logic             space_wins;

    logic             m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [CH_W-1:0]  m_user_reg;

    // Whole back pipeline moves unless a result is stuck at the output
    assign adv     = !m_valid_reg || m_axis_tready;
    assign q_ready = adv;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Stage 1: multiply sample by both references
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && q_valid) begin
            last1_reg   <= q_item.last;
            valid1_reg  <= q_item.valid;
            active1_reg <= q_item.active;
            ch1_reg     <= q_item.channel;
            mprod1_reg  <= PROD_W'(q_item.sample) * PROD_W'(q_item.mark_coef);
            sprod1_reg  <= PROD_W'(q_item.sample) * PROD_W'(q_item.space_coef);
        end
    end

    // Stage 2: saturating accumulate, latch and clear at end of buffer
    assign mark_acc_upd  = sat_add(mark_acc_reg, mprod1_reg);
    assign space_acc_upd = sat_add(space_acc_reg, sprod1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_acc_reg  <= '0;
            space_acc_reg <= '0;
            v2_reg        <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && last1_reg && valid1_reg;
            if (v1_reg) begin
                if (last1_reg) begin
                    mark_acc_reg  <= '0;
                    space_acc_reg <= '0;
                end else begin
                    mark_acc_reg  <= mark_acc_upd;
                    space_acc_reg <= space_acc_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v1_reg && last1_reg) begin
            mark_fin_reg  <= mark_acc_upd;
            space_fin_reg <= space_acc_upd;
            active2_reg   <= active1_reg;
            ch2_reg       <= ch1_reg;
        end
    end

    // Stage 3: absolute values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v2_reg) begin
            mark_abs_reg  <= acc_abs(mark_fin_reg);
            space_abs_reg <= acc_abs(space_fin_reg);
            active3_reg   <= active2_reg;
            ch3_reg       <= ch2_reg;
        end
    end

    // Stage 4: decide and update the channel status
    assign mark_wins  = (mark_abs_reg > space_abs_reg);
    assign space_wins = (space_abs_reg > mark_abs_reg);

    always_comb begin
        carrier_next = 1'b0;
        tone_next    = tone_reg[ch3_reg];
        pkt_next     = pkt_cnt_reg[ch3_reg];
        err_next     = err_cnt_reg[ch3_reg];
        if (active3_reg) begin
            pkt_next = pkt_cnt_reg[ch3_reg] + 1'b1;
            if (mark_wins) begin
                tone_next    = TONE_MARK;
                carrier_next = 1'b1;
            end else if (space_wins) begin
                tone_next    = TONE_SPACE;
                carrier_next = 1'b1;
            end else begin
                tone_next = TONE_NONE;
                err_next  = err_cnt_reg[ch3_reg] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                carrier_reg[i] <= (i == 0) || (i == 2);
                tone_reg[i]    <= (i == 0) ? TONE_MARK :
                                  (i == 2) ? TONE_SPACE : TONE_NONE;
                pkt_cnt_reg[i] <= '0;
                err_cnt_reg[i] <= '0;
            end
        end else if (adv && v3_reg) begin
            carrier_reg[ch3_reg] <= carrier_next;
            tone_reg[ch3_reg]    <= tone_next;
            pkt_cnt_reg[ch3_reg] <= pkt_next;
            err_cnt_reg[ch3_reg] <= err_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v3_reg) begin
            m_user_reg <= ch3_reg;
            m_data_reg <= {5'b0, err_next, pkt_next, carrier_next, tone_next};
        end
    end

endmodule

@@ src/ftc_checker.sv @@
module ftc_checker
    import ftc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [MASK_W-1:0]      cfg_wr_data,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [SAMPLE_BITS-1:0] s_axis_tdata,
    input logic [CH_W-1:0]        s_axis_tuser,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [M_TDATA_W-1:0]   m_axis_tdata,
    input logic [CH_W-1:0]        m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Report only real channels
    a_out_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> 32'(m_axis_tuser) < NUM_CHANNELS)
        else $error("result on a channel that does not exist");

    // Tone code is one of the three defined
    a_tone_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined tone code");

    // Carrier on means a tone was decided
    a_carrier_tone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] != TONE_NONE)
        else $error("carrier on with no tone");

    // Padding bits stay clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:67] == '0)
        else $error("padding bits set");

endmodule

bind fsk_tone_correlator_core ftc_checker u_checker (.*);

@@ tb/tb_fsk_tone_correlator_core.sv @@
`timescale 1ns / 1ps

module tb_fsk_tone_correlator_core
    import ftc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

    // Result tdata layout
    localparam int TONE_LSB    = 0;
    localparam int CARRIER_BIT = 2;
    localparam int PKT_LSB     = 3;
    localparam int ERR_LSB     = PKT_LSB + CNT_W;
    localparam int PAD_LSB     = ERR_LSB + CNT_W;

    typedef enum logic [1:0] {
        SIG_MARK,
        SIG_SPACE,
        SIG_NOISE,
        SIG_SILENT
    } sig_kind_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]               channel;
        logic                          last;
        int                            gap;
    } sample_item_t;

    typedef struct {
        logic [CH_W-1:0]  channel;
        tone_t            tone;
        logic             carrier;
        logic [CNT_W-1:0] packets;
        logic [CNT_W-1:0] errors;
    } chan_status_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [MASK_W-1:0]      cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_BITS-1:0] s_axis_tdata;
    logic [CH_W-1:0]        s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [CH_W-1:0]        m_axis_tuser;

    fsk_tone_correlator_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Q1.15 sine over one period of the table
    int tone_ref_sine [TABLE_LEN] = '{
        0, 5126, 10126, 14876, 19260, 23170, 26509, 29196, 31163, 32364,
        32767, 32364, 31163, 29196, 26509, 23170, 19260, 14876, 10126, 5126,
        0, -5126, -10126, -14876, -19260, -23170, -26509, -29196, -31163, -32364,
        -32767, -32364, -31163, -29196, -26509, -23170, -19260, -14876, -10126, -5126
    };

    // Detector state as the testbench tracks it
    logic [MASK_W-1:0] mask_model;
    int unsigned       phase_model;
    longint            mark_acc_model;
    longint            space_acc_model;
    logic              carrier_model [NUM_CHANNELS];
    tone_t             tone_model    [NUM_CHANNELS];
    logic [CNT_W-1:0]  packet_model  [NUM_CHANNELS];
    logic [CNT_W-1:0]  error_model   [NUM_CHANNELS];

    sample_item_t sample_q [$];
    chan_status_t status_q [$];

    sample_item_t next_item;
    sample_item_t shown_item;
    bit           next_loaded;
    bit           sample_taken;
    bit           status_taken;
    bit           hold_request;
    bit           calm;
    bit           rx_calm;
    int           gap_left;
    int           hold_left;
    int           stall_left;
    int           idle_cycles;
    int           fail_count;
    int           items_queued;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_acc(input longint acc, input longint prod);
        longint s;
        s = acc + prod;
        if (s > ACC_HI) begin
            s = ACC_HI;
        end else if (s < ACC_LO) begin
            s = ACC_LO;
        end
        return s;
    endfunction

    // Fold one accepted sample into the detector state; queue the status it produces
    task automatic correlate_sample(input sample_item_t it);
        int           ch;
        bit           valid;
        bit           active;
        longint       s;
        longint       mag_mark;
        longint       mag_space;
        chan_status_t st;
        ch     = it.channel;
        valid  = (ch < NUM_CHANNELS);
        active = valid ? mask_model[ch] : 1'b0;
        if (active) begin
            s               = longint'(it.sample);
            mark_acc_model  = clamp_acc(mark_acc_model,
                                        s * tone_ref_sine[(MARK_STEP * phase_model) % TABLE_LEN]);
            space_acc_model = clamp_acc(space_acc_model,
                                        s * tone_ref_sine[(SPACE_STEP * phase_model) % TABLE_LEN]);
            phase_model     = (phase_model + 1) % TABLE_LEN;
        end
        if (it.last) begin
            mag_mark        = (mark_acc_model < 0) ? -mark_acc_model : mark_acc_model;
            mag_space       = (space_acc_model < 0) ? -space_acc_model : space_acc_model;
            phase_model     = 0;
            mark_acc_model  = 0;
            space_acc_model = 0;
            if (valid) begin
                if (active) begin
                    packet_model[ch] = packet_model[ch] + 1'b1;
                    if (mag_mark > mag_space) begin
                        tone_model[ch]    = TONE_MARK;
                        carrier_model[ch] = 1'b1;
                    end else if (mag_space > mag_mark) begin
                        tone_model[ch]    = TONE_SPACE;
                        carrier_model[ch] = 1'b1;
                    end else begin
                        tone_model[ch]    = TONE_NONE;
                        carrier_model[ch] = 1'b0;
                        error_model[ch]   = error_model[ch] + 1'b1;
                    end
                end else begin
                    carrier_model[ch] = 1'b0;
                end
                st.channel = it.channel;
                st.tone    = tone_model[ch];
                st.carrier = carrier_model[ch];
                st.packets = packet_model[ch];
                st.errors  = error_model[ch];
                status_q.push_back(st);
            end
        end
    endtask

    // Record an accepted sample
    always @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            correlate_sample(shown_item);
            sample_taken = 1'b1;
        end
    end

    // Offer samples: hold until taken, then wait out the next item's gap
    always @(negedge aclk) begin : drive_samples
        logic offer;
        offer = s_axis_tvalid;
        if (sample_taken) begin
            sample_taken = 1'b0;
            offer        = 1'b0;
        end
        if (!offer) begin
            if (!next_loaded && sample_q.size() > 0) begin
                next_item   = sample_q.pop_front();
                gap_left    = next_item.gap;
                next_loaded = 1'b1;
            end
            if (next_loaded) begin
                if (gap_left == 0) begin
                    shown_item   = next_item;
                    next_loaded  = 1'b0;
                    offer        = 1'b1;
                    s_axis_tdata <= next_item.sample;
                    s_axis_tuser <= next_item.channel;
                    s_axis_tlast <= next_item.last;
                end else begin
                    gap_left--;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // Drive tready: a long hold when asked, else a random stall per item unless rx_calm
    always @(negedge aclk) begin : drive_ready
        logic ready;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (status_taken) begin
            status_taken = 1'b0;
            stall_left   = rx_calm ? 0 : $urandom_range(0, 11);
        end
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
        end else begin
            ready = 1'b1;
        end
        m_axis_tready <= ready;
    end

    // Compare each status item with the oldest prediction
    always @(posedge aclk) begin : check_status
        chan_status_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            status_taken = 1'b1;
            if (status_q.size() == 0) begin
                $error("status item on channel %0d arrived with none predicted", m_axis_tuser);
                fail_count++;
            end else begin
                want = status_q.pop_front();
                if (m_axis_tuser !== want.channel) begin
                    $error("out_channel: expected %0d, got %0d", want.channel, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[TONE_LSB +: 2] !== want.tone) begin
                    $error("tone: expected %0d, got %0d", want.tone,
                           m_axis_tdata[TONE_LSB +: 2]);
                    fail_count++;
                end
                if (m_axis_tdata[CARRIER_BIT] !== want.carrier) begin
                    $error("carrier_on: expected %0d, got %0d", want.carrier,
                           m_axis_tdata[CARRIER_BIT]);
                    fail_count++;
                end
                if (m_axis_tdata[PKT_LSB +: CNT_W] !== want.packets) begin
                    $error("packet_count: expected %0d, got %0d", want.packets,
                           m_axis_tdata[PKT_LSB +: CNT_W]);
                    fail_count++;
                end
                if (m_axis_tdata[ERR_LSB +: CNT_W] !== want.errors) begin
                    $error("error_count: expected %0d, got %0d", want.errors,
                           m_axis_tdata[ERR_LSB +: CNT_W]);
                    fail_count++;
                end
                if (m_axis_tdata[M_TDATA_W-1:PAD_LSB] !== '0) begin
                    $error("tdata padding: expected 0, got %0h",
                           m_axis_tdata[M_TDATA_W-1:PAD_LSB]);
                    fail_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_sample(input int value, input int ch, input bit last);
        sample_item_t it;
        it.sample  = value[SAMPLE_BITS-1:0];
        it.channel = ch[CH_W-1:0];
        it.last    = last;
        it.gap     = calm ? 0 : $urandom_range(0, 11);
        sample_q.push_back(it);
        items_queued++;
    endtask

    function automatic int random_sample();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // One buffer on a channel: a tone at the mark or space step, noise or silence
    task automatic push_buffer(input int ch, input int len, input sig_kind_t kind);
        int amp;
        int noise;
        int step;
        int v;
        int k;
        amp   = $urandom_range(1, 45000);
        noise = $urandom_range(0, 2000);
        step  = (kind == SIG_SPACE) ? SPACE_STEP : MARK_STEP;
        for (k = 0; k < len; k++) begin
            case (kind)
                SIG_SILENT: begin
                    v = 0;
                end
                SIG_NOISE: begin
                    v = random_sample();
                end
                default: begin
                    v = ((amp * tone_ref_sine[(step * k) % TABLE_LEN]) >>> 15)
                        + int'($urandom_range(0, 2 * noise)) - noise;
                end
            endcase
            if (v > 32767) begin
                v = 32767;
            end else if (v < -32768) begin
                v = -32768;
            end
            push_sample(v, ch, k == len - 1);
        end
    endtask

    // Mostly clean buffers, some with hopping channels or no end mark, some loose noise
    task automatic random_phase(input int n_items);
        int stop;
        int ch;
        int len;
        int pick;
        int k;
        stop = items_queued + n_items;
        while (items_queued < stop) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            ch   = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                              : $urandom_range(1, 40);
            if (pick < 70) begin
                push_buffer(ch, len, sig_kind_t'($urandom_range(0, 3)));
            end else if (pick < 85) begin
                for (k = 0; k < len; k++) begin
                    push_sample(random_sample(),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : ch,
                                (k == len - 1) && ($urandom_range(0, 1) == 1));
                end
            end else begin
                for (k = 0; k < 4; k++) begin
                    push_sample(random_sample(), $urandom_range(0, 3),
                                $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // Wait until every item is taken and every status has come back, then let the pipe drain
    task automatic settle();
        while (sample_q.size() > 0 || next_loaded || s_axis_tvalid || status_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mask(input logic [MASK_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        mask_model = value;
    endtask

    initial begin : stimulus
        logic [MASK_W-1:0] masks [8];
        int i;
        masks = '{3'b000, 3'b101, 3'b111, 3'b011, 3'b100, 3'b110, 3'b001, 3'b010};

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;

        // State after reset
        mask_model      = MASK_RESET;
        phase_model     = 0;
        mark_acc_model  = 0;
        space_acc_model = 0;
        for (i = 0; i < NUM_CHANNELS; i++) begin
            carrier_model[i] = 1'b0;
            tone_model[i]    = TONE_NONE;
            packet_model[i]  = '0;
            error_model[i]   = '0;
        end
        carrier_model[0] = 1'b1;
        tone_model[0]    = TONE_MARK;
        carrier_model[2] = 1'b1;
        tone_model[2]    = TONE_SPACE;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: all channels enabled from reset
        // single silent sample ties: no tone, carrier off, one error
        push_sample(0, 1, 1'b1);
        // full-scale extremes
        push_sample(32767, 0, 1'b0);
        push_sample(-32768, 0, 1'b0);
        push_sample(32767, 0, 1'b0);
        push_sample(-32768, 0, 1'b1);
        // channel 3 mid-buffer is skipped without advancing the phase
        push_sample(100, 2, 1'b0);
        push_sample(-32768, 3, 1'b0);
        push_sample(-1, 2, 1'b1);
        // end mark on channel 3 clears the sums and gives no status
        push_sample(32767, 0, 1'b0);
        push_sample(32767, 0, 1'b0);
        push_sample(32767, 3, 1'b1);
        push_sample(0, 2, 1'b0);
        push_sample(0, 2, 1'b1);
        // mixed channels share the sums; the channel with the end mark gets the decision
        push_sample(20000, 1, 1'b0);
        push_sample(-20000, 2, 1'b0);
        push_sample(12345, 0, 1'b1);
        push_sample(5, 3, 1'b0);
        push_sample(-32768, 1, 1'b0);
        push_sample(32767, 1, 1'b1);

        // Directed: only channel 1 enabled
        set_mask(3'b010);
        // disabled channel: carrier drops, tone and counts stay
        push_sample(32767, 0, 1'b0);
        push_sample(-32768, 0, 1'b1);
        push_sample(0, 2, 1'b1);
        push_sample(12000, 2, 1'b0);
        push_sample(-12000, 1, 1'b0);
        push_sample(30000, 1, 1'b1);
        push_sample(0, 1, 1'b1);

        // Random phases across mask settings
        for (i = 0; i < 8; i++) begin
            set_mask((i == 7) ? MASK_W'($urandom_range(0, 7)) : masks[i]);
            rx_calm = (i % 3 == 1);
            random_phase(150);
        end

        // Hold the result side so the block fills and stalls its input
        set_mask(3'b111);
        rx_calm      = 1'b0;
        calm         = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 40; i++) begin
            push_buffer($urandom_range(0, 2), $urandom_range(1, 3),
                        sig_kind_t'($urandom_range(0, 3)));
        end

        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
